@@ rtl/core/subharmonic_octave_divider_macros.svh @@
// Assertion macros for the subharmonic octave divider core.
// Expects i_clk and i_rst_n in the scope of every use.
`ifndef SUBHARMONIC_OCTAVE_DIVIDER_MACROS_SVH
`define SUBHARMONIC_OCTAVE_DIVIDER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SOD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SOD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/sod_pkg.sv @@
// Shared types, constants and the sine table function of the subharmonic octave divider.
// No dependencies.
package sod_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int SINE_DEPTH    = 1024;
    localparam int IDX_BITS      = $clog2(SINE_DEPTH);
    localparam int COEF_BITS     = 24;
    localparam int GAIN_BITS     = 16;
    localparam int PHASE_BITS    = 24;
    localparam int SINE_BITS     = 25;
    localparam int LOW_BITS      = SAMPLE_BITS + 2;
    localparam int DIFF_BITS     = LOW_BITS + 1;
    localparam int SUB_BITS      = SAMPLE_BITS + 1;
    localparam int MX_BITS       = 25;
    localparam int PROD_BITS     = MX_BITS + DIFF_BITS;
    localparam int ACC_BITS      = PROD_BITS + 1;
    localparam int THR_BITS      = SAMPLE_BITS + 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;

    localparam longint ONE_Q24 = 64'sd16777216;

    // Register reset values
    localparam logic [GAIN_BITS-1:0]  RST_WET_GAIN  = 16'd9830;
    localparam logic [GAIN_BITS-1:0]  RST_DRY_GAIN  = 16'd32768;
    localparam logic [COEF_BITS-1:0]  RST_THRESHOLD = 24'd526226;
    localparam logic [COEF_BITS-1:0]  RST_COEF      = 24'd264412;
    localparam logic [COEF_BITS-1:0]  RST_RELEASE   = 24'd16774880;
    localparam logic [PHASE_BITS-1:0] RST_STEP      = 24'd3120;

    typedef enum logic [1:0] {
        MODE_DISTORT = 2'd0,
        MODE_DIVIDE  = 2'd1,
        MODE_INVERT  = 2'd2,
        MODE_KEY     = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_MODE       = 3'd0,
        REG_WET_GAIN   = 3'd1,
        REG_DRY_GAIN   = 3'd2,
        REG_THRESHOLD  = 3'd3,
        REG_COEF       = 3'd4,
        REG_RELEASE    = 3'd5,
        REG_PHASE_STEP = 3'd6
    } t_reg_idx;

    typedef struct packed {
        t_mode                  mode;
        logic [GAIN_BITS-1:0]   wet_gain;
        logic [GAIN_BITS-1:0]   dry_gain;
        logic [COEF_BITS-1:0]   threshold;
        logic [COEF_BITS-1:0]   filter_coef;
        logic [COEF_BITS-1:0]   release_factor;
        logic [PHASE_BITS-1:0]  phase_step;
    } t_cfg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_A_MUL,
        ST_A_UPD,
        ST_B_MUL,
        ST_B_UPD,
        ST_DETECT,
        ST_ENV_UPD,
        ST_OSC_MUL,
        ST_OSC_UPD,
        ST_C_MUL,
        ST_C_UPD,
        ST_D_MUL,
        ST_D_UPD,
        ST_DRY_MUL,
        ST_WET_MUL,
        ST_MIX,
        ST_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_MUL_A,
        OP_UPD_A,
        OP_MUL_B,
        OP_UPD_B,
        OP_DETECT,
        OP_UPD_ENV,
        OP_MUL_OSC,
        OP_UPD_OSC,
        OP_MUL_C,
        OP_UPD_C,
        OP_MUL_D,
        OP_UPD_D,
        OP_MUL_DRY,
        OP_MUL_WET,
        OP_MIX,
        OP_LOAD_OUT
    } t_dp_op;

    typedef struct packed {
        logic   capture;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic key_mode;
    } t_dp_status;

    // One sine table entry, Q2.23, from a polynomial per quadrant.
    function automatic logic signed [SINE_BITS-1:0] sine_entry(input int i);
        longint q;
        longint z;
        longint w;
        longint w2;
        longint u;
        longint r;
        q  = (4 * longint'(i)) / SINE_DEPTH;
        z  = (((4 * longint'(i)) % SINE_DEPTH) * ONE_Q24) / SINE_DEPTH;
        w  = q[0] ? ONE_Q24 - z : z;
        w2 = (w * w) >>> 24;
        u  = 64'sd10837569 - ((w2 * 64'sd1337021) >>> 24);
        u  = 64'sd26353589 - ((w2 * u) >>> 24);
        r  = (w * u) >>> 24;
        r  = (r + 1) >>> 1;
        if (r > 64'sd8388608) begin
            r = 64'sd8388608;
        end
        return SINE_BITS'(q[1] ? -r : r);
    endfunction

endpackage

@@ rtl/core/sod_ifs.sv @@
// Channel interfaces of the subharmonic octave divider: sample in, sample out, register write.
// Depends on sod_pkg.
interface sod_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [sod_pkg::SAMPLE_BITS-1:0] in_sample;
    logic                                   block_start;

    modport source (output valid, output in_sample, output block_start, input ready);
    modport sink   (input valid, input in_sample, input block_start, output ready);
endinterface

interface sod_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [sod_pkg::SAMPLE_BITS-1:0] out_sample;

    modport source (output valid, output out_sample, input ready);
    modport sink   (input valid, input out_sample, output ready);
endinterface

interface sod_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [sod_pkg::CFG_IDX_BITS-1:0]   index;
    logic [sod_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/subharmonic_octave_divider.sv @@
// Top level of the subharmonic octave divider: octave-down sub-bass generator per audio sample.
// Depends on sod_pkg, sod_ifs, sod_regs, sod_ctrl and sod_dpath.
//
// Use:
//   i_in   sample requests (in_sample Q1.23, block_start); taken when valid and ready meet.
//   o_out  result requests (out_sample Q1.23, dry plus wet mix, saturated).
//   i_cfg  register writes (index, data); always ready. Write only while the block is idle.
// Sequencing:
//   ready on i_in is high only while the sequencer idles, so one request is in work at a time.
//   A request steps through the one shared 25 x 27 bit multiplier: lowpass products A and B,
//   each followed by a step that rounds and stores it, then the detector step, which also forms
//   the envelope product; in key mode the envelope update and the sine product with its store
//   follow. Lowpass products C and D, each with its store, and the dry and wet mix products,
//   summed, come next; the rounded and saturated mix then loads into the output register.
// Reset (synchronous, active low):
//   filter states, envelope and phase clear, divider signs go to +1, registers to defaults.
//   The sine table is constant logic, so there is no clearing pass.
// Stall:
//   a result waits in the output register while o_out.ready is low; the next request is still
//   accepted and worked, then holds in its final step until the register frees.
module subharmonic_octave_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sod_in_if.sink      i_in,
    sod_out_if.source   o_out,
    sod_cfg_if.sink     i_cfg
);

    sod_pkg::t_cfg          w_cfg;
    sod_pkg::t_dp_cmd       w_cmd;
    sod_pkg::t_dp_status    w_status;

    // Configuration registers
    sod_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg.valid),
        .o_wr_ready (i_cfg.ready),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (w_cfg)
    );

    // Sequencer: owns both handshakes, steps the datapath
    sod_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Arithmetic around the shared multiplier, output register included
    sod_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_in_sample   (i_in.in_sample),
        .i_block_start (i_in.block_start),
        .o_out_sample  (o_out.out_sample)
    );

endmodule

@@ rtl/core/sod_regs.sv @@
// Configuration register file of the subharmonic octave divider.
// Depends on sod_pkg.
module sod_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr_valid,
    output logic                                o_wr_ready,
    input  logic [sod_pkg::CFG_IDX_BITS-1:0]    i_wr_index,
    input  logic [sod_pkg::CFG_DATA_BITS-1:0]   i_wr_data,
    output sod_pkg::t_cfg                       o_cfg
);

    sod_pkg::t_cfg r_cfg;

    assign o_wr_ready = 1'b1;
    assign o_cfg      = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode           <= sod_pkg::MODE_DISTORT;
            r_cfg.wet_gain       <= sod_pkg::RST_WET_GAIN;
            r_cfg.dry_gain       <= sod_pkg::RST_DRY_GAIN;
            r_cfg.threshold      <= sod_pkg::RST_THRESHOLD;
            r_cfg.filter_coef    <= sod_pkg::RST_COEF;
            r_cfg.release_factor <= sod_pkg::RST_RELEASE;
            r_cfg.phase_step     <= sod_pkg::RST_STEP;
        end else if (i_wr_valid) begin
            // Drop writes to indexes past the list; mask value to the field width.
            unique case (sod_pkg::t_reg_idx'(i_wr_index))
                sod_pkg::REG_MODE:       r_cfg.mode           <= sod_pkg::t_mode'(i_wr_data[1:0]);
                sod_pkg::REG_WET_GAIN:   r_cfg.wet_gain       <= i_wr_data[sod_pkg::GAIN_BITS-1:0];
                sod_pkg::REG_DRY_GAIN:   r_cfg.dry_gain       <= i_wr_data[sod_pkg::GAIN_BITS-1:0];
                sod_pkg::REG_THRESHOLD:  r_cfg.threshold      <= i_wr_data[sod_pkg::COEF_BITS-1:0];
                sod_pkg::REG_COEF:       r_cfg.filter_coef    <= i_wr_data[sod_pkg::COEF_BITS-1:0];
                sod_pkg::REG_RELEASE:    r_cfg.release_factor <= i_wr_data[sod_pkg::COEF_BITS-1:0];
                sod_pkg::REG_PHASE_STEP: r_cfg.phase_step     <= i_wr_data[sod_pkg::PHASE_BITS-1:0];
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/core/sod_ctrl.sv @@
// Sequencing state machine of the subharmonic octave divider: handshakes and datapath commands.
// Depends on sod_pkg and subharmonic_octave_divider_macros.svh.
`include "subharmonic_octave_divider_macros.svh"

module sod_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  sod_pkg::t_dp_status i_status,
    output sod_pkg::t_dp_cmd    o_cmd
);

    sod_pkg::t_state r_state;
    sod_pkg::t_state n_state;
    logic            r_out_valid;
    logic            w_load;
    logic            w_in_acc;

    assign w_in_acc    = (r_state == sod_pkg::ST_IDLE) && i_in_valid;
    assign w_load      = (r_state == sod_pkg::ST_OUT) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sod_pkg::ST_IDLE:    if (i_in_valid) n_state = sod_pkg::ST_A_MUL;
            sod_pkg::ST_A_MUL:   n_state = sod_pkg::ST_A_UPD;
            sod_pkg::ST_A_UPD:   n_state = sod_pkg::ST_B_MUL;
            sod_pkg::ST_B_MUL:   n_state = sod_pkg::ST_B_UPD;
            sod_pkg::ST_B_UPD:   n_state = sod_pkg::ST_DETECT;
            sod_pkg::ST_DETECT: begin
                n_state = i_status.key_mode ? sod_pkg::ST_ENV_UPD : sod_pkg::ST_C_MUL;
            end
            sod_pkg::ST_ENV_UPD: n_state = sod_pkg::ST_OSC_MUL;
            sod_pkg::ST_OSC_MUL: n_state = sod_pkg::ST_OSC_UPD;
            sod_pkg::ST_OSC_UPD: n_state = sod_pkg::ST_C_MUL;
            sod_pkg::ST_C_MUL:   n_state = sod_pkg::ST_C_UPD;
            sod_pkg::ST_C_UPD:   n_state = sod_pkg::ST_D_MUL;
            sod_pkg::ST_D_MUL:   n_state = sod_pkg::ST_D_UPD;
            sod_pkg::ST_D_UPD:   n_state = sod_pkg::ST_DRY_MUL;
            sod_pkg::ST_DRY_MUL: n_state = sod_pkg::ST_WET_MUL;
            sod_pkg::ST_WET_MUL: n_state = sod_pkg::ST_MIX;
            sod_pkg::ST_MIX:     n_state = sod_pkg::ST_OUT;
            sod_pkg::ST_OUT:     if (w_load) n_state = sod_pkg::ST_IDLE;
            default:             n_state = sod_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = (r_state == sod_pkg::ST_IDLE);
        o_cmd.capture = w_in_acc;
        unique case (r_state)
            sod_pkg::ST_A_MUL:   o_cmd.op = sod_pkg::OP_MUL_A;
            sod_pkg::ST_A_UPD:   o_cmd.op = sod_pkg::OP_UPD_A;
            sod_pkg::ST_B_MUL:   o_cmd.op = sod_pkg::OP_MUL_B;
            sod_pkg::ST_B_UPD:   o_cmd.op = sod_pkg::OP_UPD_B;
            sod_pkg::ST_DETECT:  o_cmd.op = sod_pkg::OP_DETECT;
            sod_pkg::ST_ENV_UPD: o_cmd.op = sod_pkg::OP_UPD_ENV;
            sod_pkg::ST_OSC_MUL: o_cmd.op = sod_pkg::OP_MUL_OSC;
            sod_pkg::ST_OSC_UPD: o_cmd.op = sod_pkg::OP_UPD_OSC;
            sod_pkg::ST_C_MUL:   o_cmd.op = sod_pkg::OP_MUL_C;
            sod_pkg::ST_C_UPD:   o_cmd.op = sod_pkg::OP_UPD_C;
            sod_pkg::ST_D_MUL:   o_cmd.op = sod_pkg::OP_MUL_D;
            sod_pkg::ST_D_UPD:   o_cmd.op = sod_pkg::OP_UPD_D;
            sod_pkg::ST_DRY_MUL: o_cmd.op = sod_pkg::OP_MUL_DRY;
            sod_pkg::ST_WET_MUL: o_cmd.op = sod_pkg::OP_MUL_WET;
            sod_pkg::ST_MIX:     o_cmd.op = sod_pkg::OP_MIX;
            sod_pkg::ST_OUT:     o_cmd.op = w_load ? sod_pkg::OP_LOAD_OUT : sod_pkg::OP_NONE;
            default:             o_cmd.op = sod_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sod_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the result until taken; a fresh load wins over the take.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    `SOD_ASSERT_NEXT(a_accept_starts, w_in_acc, r_state == sod_pkg::ST_A_MUL, "accept did not start the sequence")
    `SOD_ASSERT_NOW(a_no_overwrite, o_cmd.op == sod_pkg::OP_LOAD_OUT, !r_out_valid || i_out_ready, "result overwritten before taken")
    `SOD_ASSERT_NEXT(a_load_shows, o_cmd.op == sod_pkg::OP_LOAD_OUT, r_out_valid, "loaded result not offered")
    `SOD_ASSERT_NOW(a_key_path, r_state == sod_pkg::ST_ENV_UPD, i_status.key_mode, "oscillator path outside key mode")

endmodule

@@ rtl/core/sod_dpath.sv @@
// Datapath of the subharmonic octave divider: filter, detector, divider, oscillator and mixer
// around one shared registered multiplier. Depends on sod_pkg.
module sod_dpath (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  sod_pkg::t_cfg                           i_cfg,
    input  sod_pkg::t_dp_cmd                        i_cmd,
    output sod_pkg::t_dp_status                     o_status,
    input  logic signed [sod_pkg::SAMPLE_BITS-1:0]  i_in_sample,
    input  logic                                    i_block_start,
    output logic signed [sod_pkg::SAMPLE_BITS-1:0]  o_out_sample
);

    localparam int SB   = sod_pkg::SAMPLE_BITS;
    localparam int LB   = sod_pkg::LOW_BITS;
    localparam int DB   = sod_pkg::DIFF_BITS;
    localparam int XB   = sod_pkg::MX_BITS;
    localparam int PB   = sod_pkg::PROD_BITS;
    localparam int AB   = sod_pkg::ACC_BITS;
    localparam int UB   = sod_pkg::SUB_BITS;
    localparam int IB   = sod_pkg::IDX_BITS;
    localparam int PHB  = sod_pkg::PHASE_BITS;

    localparam logic signed [PB-1:0]   HALF24  = PB'(1) << 23;
    localparam logic signed [PB-1:0]   HALF23  = PB'(1) << 22;
    localparam logic signed [AB-1:0]   HALF15  = AB'(1) << 14;
    localparam logic signed [UB-1:0]   SUB_ONE = UB'(1) << (SB - 1);
    localparam logic signed [LB+1:0]   DBL_ONE = (LB + 2)'(1) << (SB - 1);
    localparam logic signed [AB-1:0]   MIX_MAX = (AB'(1) << (SB - 1)) - AB'(1);
    localparam logic signed [AB-1:0]   MIX_MIN = -(AB'(1) << (SB - 1));
    localparam logic        [SB-1:0]   ENV_ONE = SB'(1) << (SB - 1);

    // Filter and oscillator state
    logic signed [LB-1:0]   r_low_a;
    logic signed [LB-1:0]   r_low_b;
    logic signed [LB-1:0]   r_low_c;
    logic signed [LB-1:0]   r_low_d;
    logic        [SB-1:0]   r_env;
    logic        [PHB-1:0]  r_phase;
    logic                   r_div_neg;
    logic                   r_oct_neg;

    // Working registers
    logic signed [SB-1:0]                   r_a;
    logic signed [UB-1:0]                   r_sub;
    logic                                   r_pos;
    logic signed [PB-1:0]                   r_prod;
    logic signed [AB-1:0]                   r_acc;
    logic signed [sod_pkg::SINE_BITS-1:0]   r_sine;
    logic signed [SB-1:0]                   r_out;

    logic signed [XB-1:0]                   w_mx;
    logic signed [DB-1:0]                   w_my;
    logic signed [PB-1:0]                   w_rnd24;
    logic signed [PB-1:0]                   w_rnd23;
    logic        [sod_pkg::THR_BITS-1:0]    w_thr_full;
    logic signed [LB-1:0]                   w_thr;
    logic                                   w_pos;
    logic                                   w_neg;
    logic                                   w_oct_new;
    logic signed [UB-1:0]                   w_tern;
    logic signed [LB+1:0]                   w_dbl;
    logic signed [LB+1:0]                   w_inv;
    logic signed [UB-1:0]                   w_inv_sat;
    logic signed [UB-1:0]                   w_sub_det;
    logic signed [AB-1:0]                   w_mix;
    logic signed [SB-1:0]                   w_mix_sat;
    logic        [PHB+IB-1:0]               w_idx_full;
    logic        [IB-1:0]                   w_idx;
    logic signed [sod_pkg::SINE_BITS-1:0]   w_sine_rom [sod_pkg::SINE_DEPTH];

    assign o_status.key_mode = (i_cfg.mode == sod_pkg::MODE_KEY);
    assign o_out_sample      = r_out;

    // Sine table, built at elaboration
    for (genvar g = 0; g < sod_pkg::SINE_DEPTH; g++) begin : g_rom
        assign w_sine_rom[g] = sod_pkg::sine_entry(g);
    end

    assign w_idx_full = (PHB + IB)'(r_phase) * (PHB + IB)'(sod_pkg::SINE_DEPTH);
    assign w_idx      = w_idx_full[PHB +: IB];

    always_ff @(posedge i_clk) begin
        r_sine <= w_sine_rom[w_idx];
    end

    // Multiplier operand selection
    always_comb begin
        w_mx = '0;
        w_my = '0;
        unique case (i_cmd.op)
            sod_pkg::OP_MUL_A: begin
                w_mx = $signed(XB'(i_cfg.filter_coef));
                w_my = (DB'(r_a) <<< 1) - DB'(r_low_a);
            end
            sod_pkg::OP_MUL_B: begin
                w_mx = $signed(XB'(i_cfg.filter_coef));
                w_my = DB'(r_low_a) - DB'(r_low_b);
            end
            sod_pkg::OP_DETECT: begin
                w_mx = $signed(XB'(i_cfg.release_factor));
                w_my = $signed(DB'(r_env));
            end
            sod_pkg::OP_MUL_OSC: begin
                w_mx = r_sine;
                w_my = $signed(DB'(r_env));
            end
            sod_pkg::OP_MUL_C: begin
                w_mx = $signed(XB'(i_cfg.filter_coef));
                w_my = DB'(r_sub) - DB'(r_low_c);
            end
            sod_pkg::OP_MUL_D: begin
                w_mx = $signed(XB'(i_cfg.filter_coef));
                w_my = DB'(r_low_c) - DB'(r_low_d);
            end
            sod_pkg::OP_MUL_DRY: begin
                w_mx = $signed(XB'(i_cfg.dry_gain));
                w_my = DB'(r_a);
            end
            sod_pkg::OP_MUL_WET: begin
                w_mx = $signed(XB'(i_cfg.wet_gain));
                w_my = DB'(r_low_d);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PB'(w_mx) * PB'(w_my);
    end

    assign w_rnd24 = (r_prod + HALF24) >>> 24;
    assign w_rnd23 = (r_prod + HALF23) >>> 23;

    // Detector and divider
    assign w_thr_full = (sod_pkg::THR_BITS'(i_cfg.threshold) << (SB - 16)) >> 8;
    assign w_thr      = $signed({2'b00, w_thr_full[SB-1:0]});
    assign w_pos      = r_low_b > w_thr;
    assign w_neg      = r_low_b < -w_thr;
    assign w_oct_new  = r_oct_neg ^ (w_neg && !r_div_neg);

    always_comb begin
        priority if (w_pos) begin
            w_tern = SUB_ONE;
        end else if (w_neg) begin
            w_tern = -SUB_ONE;
        end else begin
            w_tern = '0;
        end
    end

    assign w_dbl = {r_low_b[LB-1], r_low_b, 1'b0};
    assign w_inv = w_oct_new ? -w_dbl : w_dbl;

    always_comb begin
        priority if (w_inv > DBL_ONE) begin
            w_inv_sat = SUB_ONE;
        end else if (w_inv < -DBL_ONE) begin
            w_inv_sat = -SUB_ONE;
        end else begin
            w_inv_sat = UB'(w_inv);
        end
    end

    always_comb begin
        unique case (i_cfg.mode)
            sod_pkg::MODE_DISTORT: w_sub_det = w_tern;
            sod_pkg::MODE_DIVIDE:  w_sub_det = w_oct_new ? -w_tern : w_tern;
            sod_pkg::MODE_INVERT:  w_sub_det = w_inv_sat;
            default:               w_sub_det = '0;
        endcase
    end

    // Output rounding and saturation
    assign w_mix = (r_acc + HALF15) >>> 15;

    always_comb begin
        priority if (w_mix > MIX_MAX) begin
            w_mix_sat = SB'(MIX_MAX);
        end else if (w_mix < MIX_MIN) begin
            w_mix_sat = SB'(MIX_MIN);
        end else begin
            w_mix_sat = SB'(w_mix);
        end
    end

    // State carried from sample to sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_a   <= '0;
            r_low_b   <= '0;
            r_low_c   <= '0;
            r_low_d   <= '0;
            r_env     <= '0;
            r_phase   <= '0;
            r_div_neg <= 1'b0;
            r_oct_neg <= 1'b0;
        end else begin
            if (i_cmd.capture && i_block_start) begin
                r_div_neg <= 1'b0;
                r_oct_neg <= 1'b0;
            end
            unique case (i_cmd.op)
                sod_pkg::OP_UPD_A: r_low_a <= r_low_a + LB'(w_rnd24);
                sod_pkg::OP_UPD_B: r_low_b <= r_low_b + LB'(w_rnd24);
                sod_pkg::OP_DETECT: begin
                    priority if (w_pos && r_div_neg) begin
                        r_div_neg <= 1'b0;
                    end else if (w_neg && !r_div_neg) begin
                        r_div_neg <= 1'b1;
                        r_oct_neg <= !r_oct_neg;
                    end
                end
                sod_pkg::OP_UPD_ENV: r_env <= r_pos ? ENV_ONE : SB'(w_rnd24);
                sod_pkg::OP_UPD_OSC: r_phase <= r_phase + i_cfg.phase_step;
                sod_pkg::OP_UPD_C: r_low_c <= r_low_c + LB'(w_rnd24);
                sod_pkg::OP_UPD_D: r_low_d <= r_low_d + LB'(w_rnd24);
                default: ;
            endcase
        end
    end

    // Per-sample working values
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_a <= i_in_sample;
        end
        unique case (i_cmd.op)
            sod_pkg::OP_DETECT: begin
                r_sub <= w_sub_det;
                r_pos <= w_pos;
            end
            sod_pkg::OP_UPD_OSC:  r_sub <= UB'(w_rnd23);
            sod_pkg::OP_MUL_WET:  r_acc <= AB'(r_prod);
            sod_pkg::OP_MIX:      r_acc <= r_acc + AB'(r_prod);
            sod_pkg::OP_LOAD_OUT: r_out <= w_mix_sat;
            default: ;
        endcase
    end

endmodule
